// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the run list decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define NDR_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define NDR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- hdl/ndr_pkg.sv -----
// ----------------------------------------------------------------------------
// ndr_pkg
// Types and constants shared by the run list decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ndr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned WordW   = 64;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSectorsPerCluster = 1'd0;
  localparam logic [CfgIdxW-1:0] RegVolumeBaseSector  = 1'd1;

  localparam logic [ByteW-1:0] SpcReset  = 8'd8;
  localparam logic [WordW-1:0] BaseReset = 64'd0;

  // depth of the command queue between parser and arithmetic
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_e;

  // one command from the parser to the arithmetic back end
  typedef struct packed {
    logic [WordW-1:0] offset;   // absolute cluster offset of the run
    logic [WordW-1:0] length;   // run length in clusters
    logic             sparse;
    logic             list_end;
    logic             fmt_err;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/ndr_fifo.sv -----
// ----------------------------------------------------------------------------
// ndr_fifo
// Small command queue decoupling the byte parser from the arithmetic stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ndr_pkg::cmd_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output ndr_pkg::cmd_t      data_o
);
  import ndr_pkg::*;

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [AddrW:0] DepthCnt = (AddrW + 1)'(QueueDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(QueueDepth - 1);

  cmd_t mem_q [QueueDepth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]   cnt_q, cnt_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == DepthCnt);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ndr_front.sv -----
// ----------------------------------------------------------------------------
// ndr_front
// Byte parser: walks header, length and offset bytes, tracks the running
// cluster offset and issues one command per finished run or list event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndr_front #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    run_byte_i,
  input  wire logic          list_start_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output ndr_pkg::cmd_t      cmd_o
);
  import ndr_pkg::*;

  localparam int unsigned AccW = ByteW * MAX_FIELD_BYTES;
  localparam int unsigned PosW = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;
  localparam logic [NibW-1:0] MaxNib = NibW'(MAX_FIELD_BYTES);
  localparam int unsigned WordBytes = WordW / ByteW;

  phase_e            phase_q, phase_d;
  logic [NibW-1:0]   left_q, left_d;
  logic [NibW-1:0]   osize_q, osize_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [AccW-1:0]   len_q, len_d;
  logic [AccW-1:0]   dlt_q, dlt_d;
  logic [WordW-1:0]  roff_q, roff_d;
  logic              halted_q, halted_d;

  logic              take;
  phase_e            cur_phase;
  logic              cur_halt;
  logic [WordW-1:0]  cur_roff;
  logic [NibW-1:0]   lo, hi;
  logic              hdr_zero, hdr_bad;
  logic [NibW-1:0]   left_dec;
  logic              last;
  logic [AccW-1:0]   len_mrg, dlt_mrg;
  logic              sign_fill;
  logic [WordW-1:0]  dlt_ext;
  logic [WordW-1:0]  roff_sum;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign cur_phase  = list_start_i ? PH_HEADER : phase_q;
  assign cur_halt   = !list_start_i && halted_q;
  assign cur_roff   = list_start_i ? '0 : roff_q;
  assign lo         = run_byte_i[NibW-1:0];
  assign hi         = run_byte_i[ByteW-1:NibW];
  assign hdr_zero   = (run_byte_i == '0);
  assign hdr_bad    = (lo > MaxNib) || (hi > MaxNib);
  assign left_dec   = left_q - 1'b1;
  assign last       = (left_dec == '0);

  // drop the incoming byte into its little-endian lane
  always_comb begin
    len_mrg = len_q;
    dlt_mrg = dlt_q;
    for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
      if (pos_q == PosW'(k)) begin
        len_mrg[ByteW*k +: ByteW] = len_q[ByteW*k +: ByteW] | run_byte_i;
        dlt_mrg[ByteW*k +: ByteW] = dlt_q[ByteW*k +: ByteW] | run_byte_i;
      end
    end
  end

  // sign extension above the delta's top byte, skipped while offset is zero
  assign sign_fill = run_byte_i[ByteW-1] && (cur_roff != '0);

  always_comb begin
    dlt_ext = WordW'(dlt_mrg);
    for (int k = 0; k < WordBytes; k++) begin
      if (sign_fill && (NibW'(k) >= osize_q)) begin
        dlt_ext[ByteW*k +: ByteW] = '1;
      end
    end
  end

  assign roff_sum = cur_roff + dlt_ext;

  // next state
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    osize_d  = osize_q;
    pos_d    = pos_q;
    len_d    = len_q;
    dlt_d    = dlt_q;
    roff_d   = roff_q;
    halted_d = halted_q;
    if (take) begin
      if (list_start_i) begin
        roff_d   = '0;
        halted_d = 1'b0;
        phase_d  = PH_HEADER;
        left_d   = '0;
        pos_d    = '0;
      end
      if (!cur_halt) begin
        unique case (cur_phase)
          PH_HEADER: begin
            priority if (hdr_zero || hdr_bad) begin
              halted_d = 1'b1;
            end else begin
              len_d   = '0;
              dlt_d   = '0;
              pos_d   = '0;
              osize_d = hi;
              if (lo != '0) begin
                phase_d = PH_LENGTH;
                left_d  = lo;
              end else begin
                phase_d = PH_OFFSET;
                left_d  = hi;
              end
            end
          end
          PH_LENGTH: begin
            len_d  = len_mrg;
            pos_d  = pos_q + 1'b1;
            left_d = left_dec;
            if (last) begin
              pos_d = '0;
              if (osize_q == '0) begin
                phase_d = PH_HEADER;
                left_d  = '0;
              end else begin
                phase_d = PH_OFFSET;
                left_d  = osize_q;
              end
            end
          end
          PH_OFFSET: begin
            dlt_d  = dlt_mrg;
            pos_d  = pos_q + 1'b1;
            left_d = left_dec;
            if (last) begin
              roff_d  = roff_sum;
              phase_d = PH_HEADER;
              left_d  = '0;
              pos_d   = '0;
            end
          end
          default: begin
            phase_d = PH_HEADER;
          end
        endcase
      end
    end
  end

  // command issue
  always_comb begin
    push_o = 1'b0;
    cmd_o  = '0;
    if (take && !cur_halt) begin
      unique case (cur_phase)
        PH_HEADER: begin
          priority if (hdr_zero) begin
            push_o         = 1'b1;
            cmd_o.list_end = 1'b1;
          end else if (hdr_bad) begin
            push_o        = 1'b1;
            cmd_o.fmt_err = 1'b1;
          end else begin
            push_o = 1'b0;
          end
        end
        PH_LENGTH: begin
          if (last && (osize_q == '0)) begin
            push_o       = 1'b1;
            cmd_o.sparse = 1'b1;
            cmd_o.length = WordW'(len_mrg);
          end
        end
        PH_OFFSET: begin
          if (last) begin
            push_o       = 1'b1;
            cmd_o.offset = roff_sum;
            cmd_o.length = WordW'(len_q);
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      left_q   <= '0;
      osize_q  <= '0;
      pos_q    <= '0;
      len_q    <= '0;
      dlt_q    <= '0;
      roff_q   <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      osize_q  <= osize_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      dlt_q    <= dlt_d;
      roff_q   <= roff_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ndr_back.sv -----
// ----------------------------------------------------------------------------
// ndr_back
// Two-stage arithmetic: cluster-to-sector multiply, then base add into the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire ndr_pkg::cmd_t cmd_i,
  input  wire logic [7:0]    spc_i,
  input  wire logic [63:0]   base_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [63:0]        start_sector_o,
  output logic [63:0]        sector_count_o,
  output logic               sparse_run_o,
  output logic               list_end_o,
  output logic               format_error_o
);
  import ndr_pkg::*;

  logic             m_v_q;
  logic [WordW-1:0] m_sprod_q, m_cnt_q;
  logic             m_nostart_q, m_sparse_q, m_end_q, m_err_q;
  logic             m_free, o_free;
  logic [WordW-1:0] sprod, cprod;

  assign o_free      = !out_valid_o || out_ready_i;
  assign m_free      = !m_v_q || o_free;
  assign cmd_ready_o = m_free;

  // 64 x 8 products, low 64 bits kept
  assign sprod = cmd_i.offset * spc_i;
  assign cprod = cmd_i.length * spc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (m_free) begin
        m_v_q <= cmd_valid_i;
      end
      if (o_free) begin
        out_valid_o <= m_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_free && cmd_valid_i) begin
      m_sprod_q   <= sprod;
      m_cnt_q     <= cprod;
      m_nostart_q <= cmd_i.sparse || cmd_i.list_end || cmd_i.fmt_err;
      m_sparse_q  <= cmd_i.sparse;
      m_end_q     <= cmd_i.list_end;
      m_err_q     <= cmd_i.fmt_err;
    end
    if (o_free && m_v_q) begin
      start_sector_o <= m_nostart_q ? '0 : base_i + m_sprod_q;
      sector_count_o <= m_cnt_q;
      sparse_run_o   <= m_sparse_q;
      list_end_o     <= m_end_q;
      format_error_o <= m_err_q;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ntfs_data_run_decoder.sv -----
// ----------------------------------------------------------------------------
// ntfs_data_run_decoder
// Byte-serial NTFS data run list decoder producing sector-based run extents.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one run list byte per beat (run_byte_i), list_start_i set
//                 on the first byte of each list; it clears the running
//                 cluster offset and any halt after an end marker or error.
//   out channel : one beat per finished run, per zero header (list_end_o)
//                 and per oversized header nibble (format_error_o).
//   cfg channel : index 0 = sectors per cluster, index 1 = volume base
//                 sector; always ready, write only while the decoder idles.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// Path: after the beat of its last byte, a result passes the queue write,
//   the multiply stage and the base add into the output register.
// Stall: when out_ready_i is low the pipeline and then the 2-entry command
//   queue fill, and in_ready_o drops once the queue is full; nothing is lost.
// Reset: parser waits for a header, offset zero, no result pending,
//   sectors per cluster 8, volume base 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntfs_data_run_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  run_byte_i,
  input  wire logic        list_start_i,
  // run output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      start_sector_o,
  output logic [63:0]      sector_count_o,
  output logic             sparse_run_o,
  output logic             list_end_o,
  output logic             format_error_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [63:0] cfg_wdata_i
);
  import ndr_pkg::*;

  logic [ByteW-1:0] spc_q;
  logic [WordW-1:0] base_q;

  logic q_full, q_push, q_valid, q_ready;
  cmd_t q_wdata, q_rdata;

  // config registers: always accepted, unknown indexes cannot occur
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q  <= SpcReset;
      base_q <= BaseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegSectorsPerCluster: spc_q  <= cfg_wdata_i[ByteW-1:0];
        RegVolumeBaseSector:  base_q <= cfg_wdata_i;
        default:              base_q <= base_q;
      endcase
    end
  end

  ndr_front #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .run_byte_i  (run_byte_i),
    .list_start_i(list_start_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .cmd_o       (q_wdata)
  );

  ndr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .ready_i(q_ready),
    .data_o (q_rdata)
  );

  ndr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_ready_o   (q_ready),
    .cmd_i         (q_rdata),
    .spc_i         (spc_q),
    .base_i        (base_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .start_sector_o(start_sector_o),
    .sector_count_o(sector_count_o),
    .sparse_run_o  (sparse_run_o),
    .list_end_o    (list_end_o),
    .format_error_o(format_error_o)
  );

endmodule

`default_nettype wire

// ----- hdl/ndr_checker.sv -----
// ----------------------------------------------------------------------------
// ndr_checker
// Port-level checks on the run list decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ndr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] start_sector_o,
  input wire logic [63:0] sector_count_o,
  input wire logic        sparse_run_o,
  input wire logic        list_end_o,
  input wire logic        format_error_o
);

  // a stalled beat stays offered
  `NDR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out beat dropped while stalled")

  // a beat is a run, an end marker or an error, never two of them
  `NDR_ASSERT(a_one_kind, clk_i, rst_ni, out_valid_o |-> $onehot0({sparse_run_o, list_end_o, format_error_o}), "more than one result kind flagged")

  // end markers and errors carry no extent
  `NDR_ASSERT(a_marker_zero, clk_i, rst_ni, out_valid_o && (list_end_o || format_error_o) |-> (start_sector_o == 64'd0) && (sector_count_o == 64'd0), "marker beat with nonzero extent")

  // a sparse run has no start sector
  `NDR_ASSERT(a_sparse_start, clk_i, rst_ni, out_valid_o && sparse_run_o |-> start_sector_o == 64'd0, "sparse run with nonzero start")

endmodule

bind ntfs_data_run_decoder ndr_checker u_ndr_checker (.*);

`default_nettype wire
